FILE: sv/nms_pkg.sv
// Shared types, widths and constants of the neuron MAC and sigmoid block.
// Holds the sigmoid knot table and the structs that pass between the stages.
// No dependencies.
package nms_pkg;

    localparam int DEF_NUM_WEIGHTS = 16;

    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = 40;
    localparam int SUM_W  = 24;
    localparam int ACT_W  = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = SUM_W + ACT_W;

    // Result queue depth; also the number of results that may be in flight.
    localparam int OUT_DEPTH = 8;

    // Command codes carried in the slave tuser.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Fraction bits dropped when the Q.24 sum is rounded to Q.12.
    localparam int RND_SHIFT = 12;

    // Sigmoid value held for magnitudes of 8.0 and above.
    localparam logic [ACT_W-1:0] SIG_TOP = 16'd65514;

    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
    } t_fin;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [ACT_W-1:0]        act;
    } t_res;

    // Sigmoid knots at every 0.5 from 0 to 8, in unsigned Q0.16.
    function automatic logic [ACT_W-1:0] sig_knot(input logic [4:0] k);
        logic [ACT_W-1:0] v;
        case (k)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd40793;
            5'd2:    v = 16'd47911;
            5'd3:    v = 16'd53581;
            5'd4:    v = 16'd57724;
            5'd5:    v = 16'd60565;
            5'd6:    v = 16'd62428;
            5'd7:    v = 16'd63615;
            5'd8:    v = 16'd64357;
            5'd9:    v = 16'd64816;
            5'd10:   v = 16'd65097;
            5'd11:   v = 16'd65269;
            5'd12:   v = 16'd65374;
            5'd13:   v = 16'd65438;
            5'd14:   v = 16'd65476;
            5'd15:   v = 16'd65500;
            default: v = SIG_TOP;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/nms_mac.sv
// Weight table, multiplier and saturating accumulator of the neuron.
// Emits the accumulated Q.24 sum when a sample marked last has been added.
// Depends on nms_pkg.
module nms_mac import nms_pkg::*; #(
    parameter int NUM_WEIGHTS = DEF_NUM_WEIGHTS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_cmd,
    input  logic [IDX_W-1:0]        i_index,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_last,
    output t_fin                    o_fin
);

    // Only entries that the index field can reach need storage.
    localparam int TBL_DEPTH = (NUM_WEIGHTS < (1 << IDX_W)) ? NUM_WEIGHTS : (1 << IDX_W);
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic                    r_s1_valid;
    logic                    r_s1_cmd;
    logic [IDX_W-1:0]        r_s1_index;
    logic signed [VAL_W-1:0] r_s1_value;
    logic                    r_s1_last;

    logic signed [VAL_W-1:0] r_table [TBL_DEPTH];

    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [ACC_W-1:0] r_acc;
    t_fin                    r_fin;

    logic                    s1_hit;
    logic signed [VAL_W-1:0] s1_weight;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W:0]   acc_wide;
    logic signed [ACC_W-1:0] n_acc_sat;

    assign s1_hit    = (32'(r_s1_index) < TBL_DEPTH);
    assign s1_weight = s1_hit ? r_table[r_s1_index[TBL_AW-1:0]] : '0;
    assign n_prod    = PROD_W'(s1_weight) * PROD_W'(r_s1_value);

    assign acc_wide = {r_acc[ACC_W-1], r_acc}
                    + {{(ACC_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
            n_acc_sat = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_acc_sat = acc_wide[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc      <= '0;
            r_fin      <= '0;
            for (int i = 0; i < TBL_DEPTH; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            r_s1_valid <= i_valid;
            r_s1_cmd   <= i_cmd;
            r_s1_index <= i_index;
            r_s1_value <= i_value;
            r_s1_last  <= i_last;

            // Loads write here, so the very next sample sees the new weight.
            if (r_s1_valid && r_s1_cmd == CMD_LOAD && s1_hit) begin
                r_table[r_s1_index[TBL_AW-1:0]] <= r_s1_value;
            end

            r_s2_valid <= r_s1_valid && r_s1_cmd == CMD_SAMPLE;
            r_s2_last  <= r_s1_last;
            r_prod     <= n_prod;

            r_fin.valid <= r_s2_valid && r_s2_last;
            r_fin.acc   <= n_acc_sat;
            if (r_s2_valid) begin
                r_acc <= r_s2_last ? '0 : n_acc_sat;
            end
        end
    end

    assign o_fin = r_fin;

endmodule

FILE: sv/nms_sigmoid.sv
// Bias add, rounding to Q11.12 with saturation, and the interpolated sigmoid.
// Two register stages; one result per cycle.
// Depends on nms_pkg.
module nms_sigmoid import nms_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_fin                    i_fin,
    input  logic signed [VAL_W-1:0] i_bias,
    output t_res                    o_res
);

    localparam int TOT_W   = ACC_W + 2;
    localparam int Q_W     = TOT_W - RND_SHIFT;
    localparam int SEG_SH  = 11;
    localparam int IP_W    = ACT_W + SEG_SH;
    localparam int MAG_TOP = 15;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic                    r_a_valid;
    logic signed [SUM_W-1:0] r_sum;
    t_res                    r_res;

    logic [TOT_W-1:0]        total;
    logic [Q_W-1:0]          q;
    logic signed [SUM_W-1:0] n_sum;

    logic [SUM_W-1:0]  mag;
    logic              big;
    logic [3:0]        seg;
    logic [SEG_SH-1:0] frac;
    logic [ACT_W-1:0]  k0;
    logic [ACT_W-1:0]  k1;
    logic [ACT_W-1:0]  diff;
    logic [IP_W-1:0]   ip;
    logic [ACT_W:0]    interp;
    logic [ACT_W-1:0]  pos;
    logic [ACT_W-1:0]  n_act;

    // Round half up: add half an LSB, then floor by dropping the low bits.
    assign total = {{2{i_fin.acc[ACC_W-1]}}, i_fin.acc}
                 + {{(TOT_W-VAL_W-RND_SHIFT){i_bias[VAL_W-1]}}, i_bias, {RND_SHIFT{1'b0}}}
                 + (TOT_W'(1) << (RND_SHIFT - 1));
    assign q = total[TOT_W-1:RND_SHIFT];

    always_comb begin
        if (q[Q_W-1:SUM_W-1] != {(Q_W-SUM_W+1){q[Q_W-1]}}) begin
            n_sum = q[Q_W-1] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = q[SUM_W-1:0];
        end
    end

    // Sigmoid of the magnitude, mirrored around one half for negative sums.
    assign mag    = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;
    assign big    = |mag[SUM_W-1:MAG_TOP];
    assign seg    = mag[MAG_TOP-1:SEG_SH];
    assign frac   = mag[SEG_SH-1:0];
    assign k0     = sig_knot({1'b0, seg});
    assign k1     = sig_knot({1'b0, seg} + 5'd1);
    assign diff   = k1 - k0;
    assign ip     = IP_W'(diff) * IP_W'(frac);
    assign interp = (ACT_W+1)'(k0)
                  + (ACT_W+1)'((ip + (IP_W'(1) << (SEG_SH - 1))) >> SEG_SH);
    assign pos    = big ? SIG_TOP : interp[ACT_W-1:0];
    assign n_act  = r_sum[SUM_W-1] ? ACT_W'((17'h10000) - (ACT_W+1)'(pos)) : pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_a_valid   <= i_fin.valid;
            r_sum       <= n_sum;
            r_res.valid <= r_a_valid;
            r_res.sum   <= r_sum;
            r_res.act   <= n_act;
        end
    end

    assign o_res = r_res;

endmodule

FILE: sv/nms_out_fifo.sv
// Small result queue in front of the master stream port.
// The writer keeps it from overflowing through its own credit count.
// Depends on nms_pkg.
module nms_out_fifo import nms_pkg::*; #(
    parameter int DEPTH = OUT_DEPTH,
    parameter int WIDTH = M_TDATA_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/neuron_mac_sigmoid.sv
// Top level of a single fixed-point neuron: weighted sum, bias and sigmoid.
// Instantiates nms_mac, nms_sigmoid and nms_out_fifo; depends on nms_pkg.
//
// Usage: the slave stream carries one item per transfer. tuser selects the
// command: a load writes a signed Q3.12 weight into the table entry given by
// the index, and a sample multiplies its Q3.12 value by the weight at its
// index and adds the product into a saturating 40-bit accumulator. tlast on
// a sample closes the vector: the bias register is added, the sum is rounded
// to Q11.12 and saturated to 24 bits, and the sigmoid of it in Q0.16 comes
// out on the master stream as one transfer. The accumulator then restarts.
// Loads and samples that are not last give no output transfer.
// Throughput is one item per cycle while o_s_tready is high. The multiply
// and accumulate each take one register stage, so the accumulator loop
// closes through r_acc alone. A last sample passes the input, product,
// accumulate, round and saturate, sigmoid and queue stages to o_m_tvalid.
// The pipeline itself never stalls. A result queue of OUT_DEPTH entries sits
// in front of the master port, and o_s_tready drops only when OUT_DEPTH
// results are pending (in flight or queued), so a stalled receiver does not
// stop intake until the queue could fill. o_s_tready comes from a register
// compare, with no path from i_m_tready. Reset clears the weight table, the
// accumulator, the bias and the queue. The user must write the bias through
// i_cfg_we / i_cfg_wdata only while the block is idle; this is not enforced.
module neuron_mac_sigmoid import nms_pkg::*; #(
    parameter int NUM_WEIGHTS = DEF_NUM_WEIGHTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [3:0] index, [19:4] value, [23:20] zero
    input  logic                  i_s_tuser,   // [0] command
    input  logic                  i_s_tlast,   // last sample of the vector
    // Master stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // [23:0] weighted_sum, [39:24] activation
    // Bias register write.
    input  logic                  i_cfg_we,
    input  logic [VAL_W-1:0]      i_cfg_wdata
);

    localparam int PEND_W = $clog2(OUT_DEPTH + 1);

    logic signed [VAL_W-1:0] r_bias_val;
    logic [PEND_W-1:0]       r_pending;

    logic s_accept;
    logic m_accept;
    logic res_start;
    t_fin fin;
    t_res res;

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign m_accept  = o_m_tvalid && i_m_tready;
    assign res_start = s_accept && i_s_tuser == CMD_SAMPLE && i_s_tlast;

    // Credit count: results accepted at the input but not yet transferred out.
    assign o_s_tready = (r_pending < PEND_W'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_val <= '0;
            r_pending  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_bias_val <= i_cfg_wdata;
            end
            if (res_start && !m_accept) begin
                r_pending <= r_pending + 1'b1;
            end else if (!res_start && m_accept) begin
                r_pending <= r_pending - 1'b1;
            end
        end
    end

    nms_mac #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_accept),
        .i_cmd   (i_s_tuser),
        .i_index (i_s_tdata[IDX_W-1:0]),
        .i_value (i_s_tdata[IDX_W+VAL_W-1:IDX_W]),
        .i_last  (i_s_tlast),
        .o_fin   (fin)
    );

    nms_sigmoid u_sigmoid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fin   (fin),
        .i_bias  (r_bias_val),
        .o_res   (res)
    );

    nms_out_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (M_TDATA_W)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res.valid),
        .i_data  ({res.act, res.sum}),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (o_m_tdata)
    );

`ifndef SYNTHESIS
    // The credit count never exceeds the queue depth.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= PEND_W'(OUT_DEPTH))
        else $error("pending result count above queue depth");

    // A queued result is always covered by a credit.
    a_valid_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_pending != '0)
        else $error("output valid without a pending result");

    // Accepting a last sample leaves at least one result pending.
    a_last_takes_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_start |=> r_pending != '0)
        else $error("last sample accepted without a pending result");

    // The bias register only changes through a configuration write.
    a_bias_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_bias_val) |-> $past(i_cfg_we))
        else $error("bias changed without a configuration write");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the neuron_mac_sigmoid block: weighted sum, bias and sigmoid.
// A directed table, random vectors and saturation stress runs are checked against a predictor
// kept in this file. Depends on nms_pkg and neuron_mac_sigmoid.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nms_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 12;    // Comfortably above the pipeline latency.
    localparam int RX_HOLD_CYCLES = 300;   // Long receiver hold-off that fills the block.
    localparam int IDLE_PCT       = 35;

    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -64'sd549755813888;
    localparam longint SUM_HI = 64'sd8388607;
    localparam longint SUM_LO = -64'sd8388608;

    // Sigmoid knots at every 0.5 from 0 to 8, in unsigned Q0.16.
    localparam int unsigned KNOT [17] = '{
        32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
        64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
    };

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [ACT_W-1:0]        act;
    } neuron_out_t;

    // One row of the directed table. Where pinned is set, the result is the one typed
    // into the row rather than the one the predictor works out.
    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        idx;
        logic [VAL_W-1:0]        val;
        logic                    last;
        logic                    pinned;
        logic signed [SUM_W-1:0] sum;
        logic [ACT_W-1:0]        act;
    } dir_row_t;

    // Directed stimulus. Weights are all zero after reset, so the first sample gives a zero
    // sum and the sigmoid midpoint. Entry 2 holds the smallest weight to show round half up
    // around zero, and entry 3 holds 1.0 to land exactly on a knot and on both ends of the
    // interpolated range. Index 15 and index 0 take the largest and smallest weights.
    localparam dir_row_t DIRECTED [19] = '{
        '{CMD_SAMPLE, 4'd0,  16'h7FFF, 1'b1, 1'b1, 24'sd0,      16'd32768},
        '{CMD_LOAD,   4'd15, 16'h7FFF, 1'b1, 1'b0, 24'sd0,      16'd0},     // last on a load
        '{CMD_LOAD,   4'd0,  16'h8000, 1'b0, 1'b0, 24'sd0,      16'd0},
        '{CMD_SAMPLE, 4'd15, 16'h7FFF, 1'b0, 1'b0, 24'sd0,      16'd0},
        '{CMD_SAMPLE, 4'd0,  16'h8000, 1'b1, 1'b0, 24'sd0,      16'd0},
        '{CMD_LOAD,   4'd2,  16'h0001, 1'b0, 1'b0, 24'sd0,      16'd0},
        '{CMD_SAMPLE, 4'd2,  16'h0800, 1'b1, 1'b0, 24'sd0,      16'd0},     // half rounds up
        '{CMD_SAMPLE, 4'd2,  16'hF800, 1'b1, 1'b1, 24'sd0,      16'd32768},
        '{CMD_SAMPLE, 4'd2,  16'hF7FF, 1'b1, 1'b0, 24'sd0,      16'd0},     // just below -half
        '{CMD_LOAD,   4'd3,  16'h1000, 1'b0, 1'b0, 24'sd0,      16'd0},
        '{CMD_SAMPLE, 4'd3,  16'h0800, 1'b1, 1'b1, 24'sd2048,   16'd40793},
        '{CMD_SAMPLE, 4'd3,  16'h7FFF, 1'b1, 1'b0, 24'sd0,      16'd0},     // top of the table
        '{CMD_SAMPLE, 4'd3,  16'h8000, 1'b1, 1'b1, -24'sd32768, 16'd22},
        '{CMD_SAMPLE, 4'd1,  16'h1234, 1'b0, 1'b0, 24'sd0,      16'd0},
        '{CMD_SAMPLE, 4'd3,  16'h0000, 1'b1, 1'b1, 24'sd0,      16'd32768},
        '{CMD_LOAD,   4'd15, 16'h8000, 1'b0, 1'b0, 24'sd0,      16'd0},     // overwrite
        '{CMD_SAMPLE, 4'd15, 16'h8000, 1'b0, 1'b0, 24'sd0,      16'd0},
        '{CMD_SAMPLE, 4'd0,  16'h8000, 1'b1, 1'b1, 24'sd524288, 16'd65514},
        '{CMD_SAMPLE, 4'd15, 16'h7FFF, 1'b1, 1'b0, 24'sd0,      16'd0}
    };

    // Clock, reset and all block inputs start at known values.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = CMD_LOAD;
    logic                 i_s_tlast   = 1'b0;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [VAL_W-1:0]     i_cfg_wdata = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;

    // Predictor state: its own copy of the weight table, the Q15.24 accumulator and the bias.
    logic signed [VAL_W-1:0] weight_tab [DEF_NUM_WEIGHTS];
    longint                  acc_q24;
    logic signed [VAL_W-1:0] bias_q12;

    // Activations still to come out, oldest first.
    neuron_out_t activation_q [$];

    bit idle_on      = 1'b0;  // Both sides idle at random while this is set.
    int hold_req     = 0;     // Receiver hold-offs asked for by the stimulus.
    int hold_done    = 0;     // Receiver hold-offs carried out.
    int mismatches   = 0;
    int items_sent   = 0;
    int loads_sent   = 0;
    int results_seen = 0;
    int bias_writes  = 0;
    int cycle_cnt    = 0;

    neuron_mac_sigmoid DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // [3:0] index, [19:4] value, [23:20] zero
        .i_s_tuser   (i_s_tuser),    // [0] command
        .i_s_tlast   (i_s_tlast),    // last sample of the vector
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // [23:0] weighted_sum, [39:24] activation
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Logistic function of a Q11.12 value: linear interpolation between knots on the
    // magnitude, held at the last knot from 8.0 up, and mirrored about one half below zero.
    function automatic logic [ACT_W-1:0] logistic_q16(input longint x);
        longint      mag;
        int unsigned seg;
        int unsigned frac;
        int unsigned diff;
        int unsigned s;
        mag = (x < 0) ? -x : x;
        if (mag >= 32768) begin
            s = KNOT[16];
        end else begin
            seg  = int'(mag >> 11);
            frac = int'(mag & 2047);
            diff = KNOT[seg + 1] - KNOT[seg];
            s    = KNOT[seg] + ((diff * frac + 1024) >> 11);
        end
        if (x < 0) begin
            s = 65536 - s;
        end
        return s[ACT_W-1:0];
    endfunction

    // Advances the predictor by one accepted item. Returns 1 when the item closes a vector,
    // with the weighted sum and activation it gives in res. The index is four bits wide and
    // the table holds sixteen entries, so an index past the table cannot occur here.
    function automatic bit neuron_step(input logic cmd, input logic [IDX_W-1:0] idx,
                                       input logic [VAL_W-1:0] val, input logic last,
                                       output neuron_out_t res);
        longint total;
        longint q;
        res = '0;
        if (cmd == CMD_LOAD) begin
            weight_tab[idx] = val;
            return 1'b0;
        end
        acc_q24 = acc_q24 + longint'($signed(val)) * longint'(weight_tab[idx]);
        if (acc_q24 > ACC_HI) acc_q24 = ACC_HI;
        if (acc_q24 < ACC_LO) acc_q24 = ACC_LO;
        if (!last) begin
            return 1'b0;
        end
        total   = acc_q24 + longint'(bias_q12) * 4096;
        acc_q24 = 0;
        // Arithmetic shift is a floor, so this rounds half up.
        q = (total + 2048) >>> RND_SHIFT;
        if (q > SUM_HI) q = SUM_HI;
        if (q < SUM_LO) q = SUM_LO;
        res.sum = q[SUM_W-1:0];
        res.act = logistic_q16(q);
        return 1'b1;
    endfunction

    // Random Q3.12 value: mostly narrow so that sums land inside the sigmoid's sloped part,
    // with the two extremes and full-width values mixed in.
    function automatic logic [VAL_W-1:0] rand_q312();
        logic [VAL_W-1:0]        raw;
        logic signed [VAL_W-1:0] shifted;
        int                      nb;
        raw = VAL_W'($urandom);
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3:    nb = 8;
            4, 5:    nb = 11;
            6, 7:    nb = 13;
            default: nb = VAL_W;
        endcase
        shifted = raw << (VAL_W - nb);
        return shifted >>> (VAL_W - nb);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offers one item on the slave stream and waits for its transfer. The predictor runs at
    // the edge of the transfer, so the expectation is queued long before the result arrives.
    task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic last,
                             input bit pinned, input neuron_out_t pinned_res);
        neuron_out_t pred;
        bit          fire;
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tlast  <= last;
        i_s_tdata  <= {4'b0000, val, idx};
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        if (cmd == CMD_LOAD) loads_sent++;
        fire = neuron_step(cmd, idx, val, last, pred);
        if (fire) activation_q.push_back(pinned ? pinned_res : pred);
    endtask

    // Stops offering and waits until every expected result is in, then lets the pipeline
    // run dry, since loads and open vectors may still be in flight without a result.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (activation_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_bias(input logic [VAL_W-1:0] v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bias_q12 = v;
        bias_writes++;
    endtask

    // Random traffic: mostly well-formed vectors of one to twelve samples with random
    // indexes and values, with weight loads between them and now and then inside a vector.
    // Loads also carry a random last flag, which the block must ignore.
    task automatic random_vectors(input int n_items);
        int start;
        int len;
        int k;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(99) < 25) begin
                send_item(CMD_LOAD, IDX_W'($urandom), rand_q312(), 1'($urandom), 1'b0, '0);
            end else begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(99) < 8) begin
                        send_item(CMD_LOAD, IDX_W'($urandom), rand_q312(), 1'($urandom),
                                  1'b0, '0);
                    end
                    send_item(CMD_SAMPLE, IDX_W'($urandom), rand_q312(), k == len - 1,
                              1'b0, '0);
                end
            end
        end
    endtask

    // One vector of first_n samples of first_val followed by then_n samples of then_val,
    // all paired with the same table entry.
    task automatic long_vector(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] first_val,
                               input int first_n, input logic [VAL_W-1:0] then_val,
                               input int then_n);
        int k;
        for (k = 0; k < first_n + then_n; k++) begin
            send_item(CMD_SAMPLE, idx, (k < first_n) ? first_val : then_val,
                      k == first_n + then_n - 1, 1'b0, '0);
        end
    endtask

    // Receiver side. It stalls at random while idling is on, and on request holds tready
    // low for a long stretch so that the result queue fills and the block stops intake.
    initial begin : receiver
        int hold_cnt;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_done) begin
                i_m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++) @(posedge i_clk);
                hold_done++;
            end else if (idle_on) begin
                i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Every result transfer is compared field by field with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        neuron_out_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (activation_q.size() == 0) begin
                report_mismatch("result with nothing pending",
                                longint'($signed(o_m_tdata[SUM_W-1:0])), 0);
            end else begin
                want = activation_q.pop_front();
                results_seen++;
                if (o_m_tdata[SUM_W-1:0] !== want.sum) begin
                    report_mismatch("weighted_sum", longint'($signed(o_m_tdata[SUM_W-1:0])),
                                    longint'(want.sum));
                end
                if (o_m_tdata[M_TDATA_W-1:SUM_W] !== want.act) begin
                    report_mismatch("activation", longint'(o_m_tdata[M_TDATA_W-1:SUM_W]),
                                    longint'(want.act));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles, %0d results pending",
                     cycle_cnt, activation_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int          k;
        bit          acc_up;
        neuron_out_t pinned_res;

        // Predictor state after reset.
        foreach (weight_tab[k]) weight_tab[k] = '0;
        acc_q24  = 0;
        bias_q12 = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset bias of zero.
        idle_on = 1'b1;
        for (k = 0; k < $size(DIRECTED); k++) begin
            pinned_res.sum = DIRECTED[k].sum;
            pinned_res.act = DIRECTED[k].act;
            send_item(DIRECTED[k].cmd, DIRECTED[k].idx, DIRECTED[k].val, DIRECTED[k].last,
                      DIRECTED[k].pinned, pinned_res);
        end

        // Largest bias, with a long stretch of back-to-back transfers on both sides.
        program_bias(16'h7FFF);
        idle_on = 1'b0;
        random_vectors(110);

        // Smallest bias, with random idling and one long receiver hold-off while the
        // sender keeps offering items.
        program_bias(16'h8000);
        idle_on = 1'b1;
        hold_req++;
        random_vectors(110);

        // Two random bias settings.
        program_bias(VAL_W'($urandom));
        random_vectors(100);
        program_bias(VAL_W'($urandom));
        random_vectors(110);

        // Saturation runs under a zero bias. Forty largest products push the sum past the
        // 24-bit range in each direction. A vector of 520 of them then runs the accumulator
        // into its 40-bit limit, where a wrapped accumulator would flip the sign of the
        // result; the direction is picked at random.
        program_bias(16'h0000);
        send_item(CMD_LOAD, 4'd5, 16'h8000, 1'b0, 1'b0, '0);
        long_vector(4'd5, 16'h8000, 40, 16'h0000, 0);
        long_vector(4'd5, 16'h7FFF, 40, 16'h0000, 0);
        acc_up = 1'($urandom);
        if (acc_up) begin
            long_vector(4'd5, 16'h8000, 520, 16'h0000, 0);
        end else begin
            long_vector(4'd5, 16'h7FFF, 520, 16'h0000, 0);
        end

        drain_results();
        $display("Covered %0d transfers in (%0d weight loads), %0d results checked,",
                 items_sent, loads_sent, results_seen);
        $display("%0d bias writes, round half up, sum and accumulator saturation, %0d-cycle hold.",
                 bias_writes, RX_HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
